// ----- rtl/tg_pkg.sv -----
// shared types, constants and tables of the pcm tone generator
package tg_pkg;

  localparam int unsigned RATE_W       = 18;
  localparam int unsigned PITCH_W      = 15;
  localparam int unsigned CHCNT_W      = 4;
  localparam int unsigned CHIDX_W      = 3;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned SUM_W        = 19;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CNT_W        = 5;

  localparam int unsigned DEF_MAX_CHANNELS       = 8;
  localparam int unsigned DEF_TURN_FRACTION_BITS = 16;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd44100;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 15'd600;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_RATE   = 3'd0,
    REG_PITCH  = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_SIGNED = 3'd3,
    REG_ENDIAN = 3'd4,
    REG_CHANS  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_RED,
    FR_DIV,
    FR_ANG,
    FR_COR,
    FR_MUL,
    FR_FMT,
    FR_PUSH
  } front_state_e;

  typedef struct packed {
    logic [RATE_W-1:0]  sample_rate;
    logic [PITCH_W-1:0] tone_pitch;
    logic               sample_width;
    logic               sample_signed;
    logic               big_endian;
    logic [CHCNT_W-1:0] channel_count;
  } cfg_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [3:0] i);
    logic signed [CORDIC_W-1:0] r;
    unique case (i)
      4'd0:  r = 34'sd536870912;
      4'd1:  r = 34'sd316933406;
      4'd2:  r = 34'sd167458907;
      4'd3:  r = 34'sd85004756;
      4'd4:  r = 34'sd42667331;
      4'd5:  r = 34'sd21354465;
      4'd6:  r = 34'sd10679838;
      4'd7:  r = 34'sd5340245;
      4'd8:  r = 34'sd2670163;
      4'd9:  r = 34'sd1335087;
      4'd10: r = 34'sd667544;
      4'd11: r = 34'sd333772;
      4'd12: r = 34'sd166886;
      4'd13: r = 34'sd83443;
      4'd14: r = 34'sd41722;
      4'd15: r = 34'sd20861;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/tg_front.sv -----
// front end: takes frame requests, runs phase, divider, cordic and sample scaling
module tg_front import tg_pkg::*; #(
  parameter int unsigned TURN_FRACTION_BITS = DEF_TURN_FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              restart_i,
  output logic              push_o,
  output logic [WORD_W-1:0] word_o,
  input  logic              full_i
);

  localparam int unsigned TFB = TURN_FRACTION_BITS;
  localparam int unsigned DIV_STEPS = (TFB > SUM_W) ? TFB : SUM_W;

  front_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RATE_W-1:0] phase_q, phase_d;
  logic [SUM_W-1:0]  rem_q, rem_d, src_q, src_d;
  logic [RATE_W-1:0] drem_q, drem_d;
  logic [TFB-1:0]    frac_q, frac_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic neg_q, neg_d;
  logic signed [35:0] prod_q, prod_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic [RATE_W-1:0] rate;
  logic [RATE_W-1:0] ph_in;
  logic [SUM_W-1:0]  rt, rem_n, ft, drem_full;
  logic [RATE_W-1:0] p_start;
  logic              start_div;
  logic [TFB-1:0]    frac_n;
  logic              fge;
  logic [31:0]       ang, ang_bias;
  logic [3:0]        idx;
  logic signed [CORDIC_W-1:0] dx, dy, xs;
  logic signed [16:0] cl, cv;
  logic signed [17:0] op, kk;
  logic signed [35:0] pneg;

  assign rate = (cfg_i.sample_rate == '0) ? RATE_W'(1) : cfg_i.sample_rate;
  assign ph_in = restart_i ? '0 : phase_q;

  assign rt    = {rem_q[SUM_W-2:0], src_q[SUM_W-1]};
  assign rem_n = (rt >= {1'b0, rate}) ? rt - {1'b0, rate} : rt;

  assign ft        = {drem_q, 1'b0};
  assign fge       = ft >= {1'b0, rate};
  assign drem_full = fge ? ft - {1'b0, rate} : ft;
  assign frac_n    = {frac_q[TFB-2:0], fge};

  assign ang      = {frac_q, {(32-TFB){1'b0}}};
  assign ang_bias = ang + 32'h4000_0000;

  assign idx = cnt_q[3:0];
  assign dx  = y_q >>> idx;
  assign dy  = x_q >>> idx;

  assign xs = x_q >>> 15;
  always_comb begin
    if (xs > 34'sd32767) begin
      cl = 17'sd32767;
    end else if (xs < -34'sd32767) begin
      cl = -17'sd32767;
    end else begin
      cl = xs[16:0];
    end
    cv = neg_q ? -cl : cl;
    op = cfg_i.sample_signed ? {cv[16], cv} : 18'sd32768 + {cv[16], cv};
    if (cfg_i.sample_signed) begin
      kk = cfg_i.sample_width ? 18'sd32767 : 18'sd127;
    end else begin
      kk = cfg_i.sample_width ? 18'sd65535 : 18'sd255;
    end
  end

  assign pneg = -prod_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    rem_d     = rem_q;
    src_d     = src_q;
    drem_d    = drem_q;
    frac_d    = frac_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    neg_d     = neg_q;
    prod_d    = prod_q;
    word_d    = word_q;
    start_div = 1'b0;
    p_start   = ph_in;
    push_o    = 1'b0;

    unique case (state_q)
      FR_IDLE: begin
        if (in_valid_i) begin
          if (ph_in < rate) begin
            start_div = 1'b1;
          end else begin
            rem_d   = '0;
            src_d   = {1'b0, ph_in};
            cnt_d   = '0;
            state_d = FR_RED;
          end
        end
      end
      FR_RED: begin
        rem_d = rem_n;
        src_d = {src_q[SUM_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          p_start   = rem_n[RATE_W-1:0];
          start_div = 1'b1;
        end
      end
      FR_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q < CNT_W'(TFB)) begin
          drem_d = drem_full[RATE_W-1:0];
          frac_d = frac_n;
        end
        if (cnt_q < CNT_W'(SUM_W)) begin
          rem_d = rem_n;
          src_d = {src_q[SUM_W-2:0], 1'b0};
          if (cnt_q == CNT_W'(SUM_W - 1)) begin
            phase_d = rem_n[RATE_W-1:0];
          end
        end
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = FR_ANG;
        end
      end
      FR_ANG: begin
        neg_d   = ang_bias[31];
        z_d     = CORDIC_W'(signed'(ang_bias[31] ? ang + 32'h8000_0000 : ang));
        x_d     = CORDIC_GAIN;
        y_d     = '0;
        cnt_d   = '0;
        state_d = FR_COR;
      end
      FR_COR: begin
        if (!z_q[CORDIC_W-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_turn(idx);
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_turn(idx);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = FR_MUL;
        end
      end
      FR_MUL: begin
        prod_d  = op * kk;
        state_d = FR_FMT;
      end
      FR_FMT: begin
        if (cfg_i.sample_signed) begin
          if (prod_q[35]) begin
            word_d = WORD_W'(-(pneg >>> 15));
          end else begin
            word_d = WORD_W'(prod_q >>> 15);
          end
        end else begin
          word_d = prod_q[31:16];
        end
        state_d = FR_PUSH;
      end
      FR_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase

    if (start_div) begin
      drem_d  = p_start;
      frac_d  = '0;
      rem_d   = '0;
      src_d   = {1'b0, p_start} + SUM_W'(cfg_i.tone_pitch);
      cnt_d   = '0;
      state_d = FR_DIV;
    end
  end

  assign in_stall_o = (state_q != FR_IDLE);
  assign word_o     = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    src_q  <= src_d;
    drem_q <= drem_d;
    frac_q <= frac_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    word_q <= word_d;
  end

endmodule

// ----- rtl/tg_fifo.sv -----
// two-entry queue of sample words between front and back end
module tg_fifo import tg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WORD_W-1:0] word_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [WORD_W-1:0] word_o
);

  logic [WORD_W-1:0] mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign word_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= word_i;
    end
  end

endmodule

// ----- rtl/tg_back.sv -----
// back end: splits each sample word into one or two bytes and repeats it per channel
module tg_back import tg_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               empty_i,
  input  logic [WORD_W-1:0]  word_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic [CHIDX_W-1:0] channel_index_o,
  output logic               last_of_frame_o
);

  logic [CHCNT_W-1:0] ch_q, chans;
  logic               b_q, hi_sel, take;

  always_comb begin
    if (cfg_i.channel_count == '0) begin
      chans = CHCNT_W'(1);
    end else if (int'(cfg_i.channel_count) > int'(MAX_CHANNELS)) begin
      chans = CHCNT_W'(MAX_CHANNELS);
    end else begin
      chans = cfg_i.channel_count;
    end
  end

  assign hi_sel          = cfg_i.sample_width & (b_q ^ cfg_i.big_endian);
  assign out_valid_o     = !empty_i;
  assign out_byte_o      = hi_sel ? word_i[15:8] : word_i[7:0];
  assign channel_index_o = ch_q[CHIDX_W-1:0];
  assign last_of_frame_o = (ch_q + 1'b1 == chans) && (b_q == cfg_i.sample_width);
  assign take            = out_valid_o && !out_stall_i;
  assign pop_o           = take && last_of_frame_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
      b_q  <= 1'b0;
    end else if (take) begin
      if (last_of_frame_o) begin
        ch_q <= '0;
        b_q  <= 1'b0;
      end else if (cfg_i.sample_width && !b_q) begin
        b_q <= 1'b1;
      end else begin
        b_q  <= 1'b0;
        ch_q <= ch_q + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pcm_tone_generator.sv -----
// pcm tone generator top level: register port, front end, queue and back end
//
// usage: each word accepted on the input channel (in_valid_i high, in_stall_o
// low) asks for one pcm frame of a cosine tone; restart_i set clears the
// phase first. the frame leaves on the output channel as one byte per 8-bit
// word or two per 16-bit word, low or high byte first as configured,
// repeated for each channel, with last_of_frame_o on its final byte.
// processing: an accepted request first reduces the phase modulo the rate
// when a rate change has left it out of range, then runs the shift-subtract
// divider (max(19, fraction bits) steps), angle setup, the 16-step cordic,
// scaling, formatting and the queue push. in_stall_o is high while a request
// is worked on, so requests are taken one at a time; the next one is taken
// only after the last word has been pushed into the queue. later bytes of a
// frame follow one per cycle while out_stall_i is low.
// a two-word queue holds finished samples, so the front end keeps working
// while the receiver stalls; the output holds its byte while out_stall_i
// is high. registers are to be written over the apb port only while idle;
// the block itself does not enforce it. reset: phase zero, rate 44100,
// pitch 600, 16-bit signed little endian, one channel, queue empty.
module pcm_tone_generator import tg_pkg::*; #(
  parameter int unsigned MAX_CHANNELS       = DEF_MAX_CHANNELS,
  parameter int unsigned TURN_FRACTION_BITS = DEF_TURN_FRACTION_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic [CHIDX_W-1:0] channel_index_o,
  output logic               last_of_frame_o
);

  cfg_t cfg_q;
  logic wr_en;
  logic push, full, pop, empty;
  logic [WORD_W-1:0] push_word, head_word;
  reg_idx_e ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate   <= RATE_RESET;
      cfg_q.tone_pitch    <= PITCH_RESET;
      cfg_q.sample_width  <= 1'b1;
      cfg_q.sample_signed <= 1'b1;
      cfg_q.big_endian    <= 1'b0;
      cfg_q.channel_count <= CHCNT_W'(1);
    end else if (wr_en) begin
      unique case (ridx)
        REG_RATE:   cfg_q.sample_rate   <= pwdata[RATE_W-1:0];
        REG_PITCH:  cfg_q.tone_pitch    <= pwdata[PITCH_W-1:0];
        REG_WIDTH:  cfg_q.sample_width  <= pwdata[0];
        REG_SIGNED: cfg_q.sample_signed <= pwdata[0];
        REG_ENDIAN: cfg_q.big_endian    <= pwdata[0];
        REG_CHANS:  cfg_q.channel_count <= pwdata[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_RATE:   prdata = DATA_W'(cfg_q.sample_rate);
      REG_PITCH:  prdata = DATA_W'(cfg_q.tone_pitch);
      REG_WIDTH:  prdata = DATA_W'(cfg_q.sample_width);
      REG_SIGNED: prdata = DATA_W'(cfg_q.sample_signed);
      REG_ENDIAN: prdata = DATA_W'(cfg_q.big_endian);
      REG_CHANS:  prdata = DATA_W'(cfg_q.channel_count);
      default:    prdata = '0;
    endcase
  end

  tg_front #(
    .TURN_FRACTION_BITS(TURN_FRACTION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .push_o     (push),
    .word_o     (push_word),
    .full_i     (full)
  );

  tg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .word_o  (head_word)
  );

  tg_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .word_i          (head_word),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .channel_index_o (channel_index_o),
    .last_of_frame_o (last_of_frame_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("front end took a request without going busy");

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_of_frame_o) |=> out_valid_o)
    else $error("frame broke off before its last byte");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("sample word pushed into a full queue");
`endif

endmodule
